### hw/rtl/mssc_pkg.sv
// Shared types, constants and signature table of the signature scanner.
`timescale 1ns / 1ps
`default_nettype none
package mssc_pkg;

    localparam int NUM_SIGS       = 27;
    localparam int SIG_BYTES      = 16;
    localparam int HIST_DEPTH     = SIG_BYTES - 1;
    localparam int MAX_REPORTED   = 16;
    localparam int POS_W          = 17;
    localparam int IDX_W          = 5;
    localparam int CNT_W          = 5;
    localparam int TOT_W          = 8;
    localparam int CAT_W          = 4;
    localparam int OFF_W          = 16;
    localparam int SCORE_W        = 4;
    localparam int CFG_IDX_W      = 8;
    localparam int CFG_DATA_W     = 4;
    localparam int IN_DATA_W      = 24;
    localparam int OUT_DATA_W     = 48;

    localparam logic [15:0] WIN_ADDR_LO = 16'hC000;
    localparam logic [15:0] WIN_ADDR_HI = 16'hCFFF;

    localparam logic [CFG_IDX_W-1:0] REG_FILTER_ENABLE   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FILTER_CATEGORY = 8'd1;

    localparam logic [CAT_W-1:0] SIG_CAT [NUM_SIGS] = '{
        4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd3, 4'd3, 4'd3, 4'd3, 4'd3, 4'd3, 4'd2, 4'd2,
        4'd2, 4'd2, 4'd2, 4'd2, 4'd4, 4'd4, 4'd4, 4'd6, 4'd6, 4'd6, 4'd6, 4'd8, 4'd8};

    localparam logic [SCORE_W-1:0] SIG_WEIGHT [NUM_SIGS] = '{
        4'd10, 4'd8, 4'd8, 4'd8, 4'd7, 4'd7, 4'd15, 4'd15, 4'd15, 4'd15, 4'd14, 4'd14,
        4'd10, 4'd8, 4'd10, 4'd9, 4'd8, 4'd8, 4'd12, 4'd12, 4'd10, 4'd10, 4'd10, 4'd10,
        4'd10, 4'd5, 4'd5};

    localparam int SIG_LEN [NUM_SIGS] = '{
        4, 4, 4, 5, 6, 8, 16, 16, 14, 8, 13, 8, 9, 5, 12, 6, 9, 9, 5, 8, 3, 8, 7, 8, 9, 5, 5};

    // byte j of each row is the j-th byte of the signature, zero padded
    localparam logic [7:0] SIG_PAT [NUM_SIGS][SIG_BYTES] = '{
        '{8'h78,8'hA2,8'h00,8'hBD,8'h00,8'h00,8'h00,8'h00,
          8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00},
        '{8'h4E,8'h4F,8'h56,8'h41,8'h00,8'h00,8'h00,8'h00,
          8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00},
        '{8'h50,8'h41,8'h56,8'h4C,8'h00,8'h00,8'h00,8'h00,
          8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00},
        '{8'h43,8'h59,8'h42,8'h45,8'h52,8'h00,8'h00,8'h00,
          8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00},
        '{8'h42,8'h55,8'h52,8'h4E,8'h45,8'h52,8'h00,8'h00,
          8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00},
        '{8'h46,8'h52,8'h45,8'h45,8'h4C,8'h4F,8'h41,8'h44,
          8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00},
        '{8'h54,8'h55,8'h52,8'h42,8'h4F,8'h20,8'h4E,8'h49,
          8'h42,8'h42,8'h4C,8'h45,8'h52,8'h20,8'h56,8'h31},
        '{8'h54,8'h55,8'h52,8'h42,8'h4F,8'h20,8'h4E,8'h49,
          8'h42,8'h42,8'h4C,8'h45,8'h52,8'h20,8'h56,8'h32},
        '{8'h52,8'h42,8'h4F,8'h20,8'h4E,8'h49,8'h42,8'h42,
          8'h4C,8'h45,8'h52,8'h20,8'h56,8'h34,8'h00,8'h00},
        '{8'h42,8'h55,8'h52,8'h53,8'h54,8'h4E,8'h49,8'h42,
          8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00},
        '{8'h53,8'h55,8'h50,8'h45,8'h52,8'h20,8'h4E,8'h49,
          8'h42,8'h42,8'h4C,8'h45,8'h52,8'h00,8'h00,8'h00},
        '{8'h4D,8'h41,8'h56,8'h45,8'h52,8'h49,8'h43,8'h4B,
          8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00},
        '{8'h54,8'h55,8'h52,8'h42,8'h4F,8'h43,8'h4F,8'h50,
          8'h59,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00},
        '{8'h46,8'h43,8'h4F,8'h50,8'h59,8'h00,8'h00,8'h00,
          8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00},
        '{8'h46,8'h41,8'h53,8'h54,8'h20,8'h48,8'h41,8'h43,
          8'h4B,8'h27,8'h45,8'h4D,8'h00,8'h00,8'h00,8'h00},
        '{8'h32,8'h31,8'h20,8'h53,8'h45,8'h43,8'h00,8'h00,
          8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00},
        '{8'h44,8'h55,8'h41,8'h4C,8'h20,8'h43,8'h4F,8'h50,
          8'h59,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00},
        '{8'h53,8'h50,8'h45,8'h45,8'h44,8'h43,8'h4F,8'h50,
          8'h59,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00},
        '{8'h56,8'h2D,8'h4D,8'h41,8'h58,8'h00,8'h00,8'h00,
          8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00},
        '{8'h52,8'h41,8'h50,8'h49,8'h44,8'h4C,8'h4F,8'h4B,
          8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00},
        '{8'h4D,8'h2D,8'h57,8'h00,8'h00,8'h00,8'h00,8'h00,
          8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00},
        '{8'h4A,8'h49,8'h46,8'h46,8'h59,8'h44,8'h4F,8'h53,
          8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00},
        '{8'h44,8'h4F,8'h4C,8'h50,8'h48,8'h49,8'h4E,8'h00,
          8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00},
        '{8'h53,8'h50,8'h45,8'h45,8'h44,8'h44,8'h4F,8'h53,
          8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00},
        '{8'h50,8'h52,8'h4F,8'h46,8'h49,8'h2D,8'h44,8'h4F,
          8'h53,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00},
        '{8'hA9,8'h00,8'h8D,8'h00,8'h18,8'h00,8'h00,8'h00,
          8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00},
        '{8'hAD,8'h00,8'hDD,8'h29,8'h40,8'h00,8'h00,8'h00,
          8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00}};

    // one finished file handed from the scanner to the reporter
    typedef struct packed {
        logic                               valid;
        logic [NUM_SIGS-1:0]                mask;
        logic [NUM_SIGS-1:0][OFF_W-1:0]     offsets;
        logic                               overflow;
    } job_t;

    typedef struct packed {
        logic                   enable;
        logic [CAT_W-1:0]       category;
    } filter_t;

endpackage
`default_nettype wire

### hw/rtl/mssc_front.sv
// Byte scanner: history window, parallel signature compare, per-file hit state.
`timescale 1ns / 1ps
`default_nettype none
module mssc_front (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [7:0]                  data_byte,
    input  wire logic                        last_byte,
    input  wire logic [15:0]                 file_addr,
    input  wire mssc_pkg::filter_t           filter,
    input  wire logic                        job_full,
    output mssc_pkg::job_t                   push
);
    import mssc_pkg::*;

    logic [7:0]                     recent_reg [HIST_DEPTH];
    logic [7:0]                     recent_next [HIST_DEPTH];
    logic [NUM_SIGS-1:0]            found_reg, found_next, hit;
    logic [NUM_SIGS-1:0][OFF_W-1:0] off_reg, off_next;
    logic [POS_W-1:0]               pos_reg, pos_next;
    logic                           ovf_reg, ovf_next, ovf_upd;
    logic [7:0]                     win [SIG_BYTES];
    logic [NUM_SIGS-1:0]            found_upd, eligible;
    logic                           accept, scan, eq, win_ok;

    // a closing byte waits while the previous file is still being reported
    assign in_ready = !(last_byte && job_full);
    assign accept   = in_valid && in_ready;
    assign scan     = !pos_reg[POS_W-1];
    assign win_ok   = (file_addr >= WIN_ADDR_LO) && (file_addr <= WIN_ADDR_HI);

    always_comb
    begin
        win[0] = data_byte;
        for (int k = 0; k < HIST_DEPTH; k++)
        begin
            win[k+1] = recent_reg[k];
        end
    end

    always_comb
    begin
        for (int i = 0; i < NUM_SIGS; i++)
        begin
            eq = (pos_reg >= POS_W'(SIG_LEN[i] - 1));
            for (int j = 0; j < SIG_BYTES; j++)
            begin
                if (j < SIG_LEN[i])
                begin
                    eq = eq && (win[SIG_LEN[i] - 1 - j] == SIG_PAT[i][j]);
                end
            end
            hit[i] = eq && scan;
        end
    end

    always_comb
    begin
        found_upd = found_reg | hit;
        ovf_upd   = ovf_reg | !scan;
        off_next  = off_reg;
        for (int i = 0; i < NUM_SIGS; i++)
        begin
            if (hit[i] && !found_reg[i])
            begin
                off_next[i] = OFF_W'(pos_reg + POS_W'(1) - POS_W'(SIG_LEN[i]));
            end
            eligible[i] = found_upd[i] && (!filter.enable || SIG_CAT[i] == filter.category);
        end
        eligible[0] = eligible[0] && win_ok;

        recent_next = recent_reg;
        found_next  = found_reg;
        pos_next    = pos_reg;
        ovf_next    = ovf_reg;
        if (accept)
        begin
            if (scan)
            begin
                recent_next[0] = data_byte;
                for (int k = 1; k < HIST_DEPTH; k++)
                begin
                    recent_next[k] = recent_reg[k-1];
                end
                pos_next = pos_reg + POS_W'(1);
            end
            found_next = found_upd;
            ovf_next   = ovf_upd;
            if (last_byte)
            begin
                for (int k = 0; k < HIST_DEPTH; k++)
                begin
                    recent_next[k] = 8'h00;
                end
                found_next = '0;
                pos_next   = '0;
                ovf_next   = 1'b0;
            end
        end

        push.valid    = accept && last_byte;
        push.mask     = eligible;
        push.offsets  = off_next;
        push.overflow = ovf_upd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < HIST_DEPTH; k++)
            begin
                recent_reg[k] <= 8'h00;
            end
            found_reg <= '0;
            pos_reg   <= '0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            recent_reg <= recent_next;
            found_reg  <= found_next;
            pos_reg    <= pos_next;
            ovf_reg    <= ovf_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            off_reg <= off_next;
        end
    end

endmodule
`default_nettype wire

### hw/rtl/mssc_back.sv
// Reporter: holds one finished file and emits its match items and summary.
`timescale 1ns / 1ps
`default_nettype none
module mssc_back (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire mssc_pkg::job_t                 push,
    input  wire mssc_pkg::filter_t              filter,
    output logic                                job_full,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic                                out_summary,
    output logic                                out_last,
    output logic [mssc_pkg::OUT_DATA_W-1:0]     out_data
);
    import mssc_pkg::*;

    logic                           job_valid_reg, job_valid_next;
    logic [NUM_SIGS-1:0]            mask_reg, mask_next;
    logic [NUM_SIGS-1:0][OFF_W-1:0] offs_reg;
    logic                           jovf_reg;
    logic [CNT_W-1:0]               cnt_reg, cnt_next;
    logic [TOT_W-1:0]               tot_reg, tot_next;
    logic [SCORE_W-1:0]             best_reg, best_next;
    logic [CAT_W-1:0]               prim_reg, prim_next;
    logic                           ov_reg, ov_next, os_reg, os_next, ol_reg, ol_next;
    logic [OUT_DATA_W-1:0]          od_reg, od_next;
    logic [IDX_W-1:0]               idx;
    logic                           step, emit_match;

    assign job_full    = job_valid_reg;
    assign out_valid   = ov_reg;
    assign out_summary = os_reg;
    assign out_last    = ol_reg;
    assign out_data    = od_reg;

    // lowest pending signature goes first
    always_comb
    begin
        idx = '0;
        for (int i = NUM_SIGS - 1; i >= 0; i--)
        begin
            if (mask_reg[i])
            begin
                idx = IDX_W'(i);
            end
        end
    end

    assign step       = job_valid_reg && (!ov_reg || out_ready);
    assign emit_match = (mask_reg != '0) && (cnt_reg < CNT_W'(MAX_REPORTED));

    always_comb
    begin
        job_valid_next = job_valid_reg;
        mask_next      = mask_reg;
        cnt_next       = cnt_reg;
        tot_next       = tot_reg;
        best_next      = best_reg;
        prim_next      = prim_reg;
        ov_next        = ov_reg && !out_ready;
        os_next        = os_reg;
        ol_next        = ol_reg;
        od_next        = od_reg;
        if (step)
        begin
            ov_next = 1'b1;
            od_next = '0;
            if (emit_match)
            begin
                mask_next[idx] = 1'b0;
                cnt_next       = cnt_reg + CNT_W'(1);
                tot_next       = tot_reg + TOT_W'(SIG_WEIGHT[idx]);
                if (cnt_reg == '0 || SIG_WEIGHT[idx] > best_reg)
                begin
                    best_next = SIG_WEIGHT[idx];
                    prim_next = SIG_CAT[idx];
                end
                os_next        = 1'b0;
                ol_next        = 1'b0;
                od_next[4:0]   = idx;
                od_next[8:5]   = SIG_CAT[idx];
                od_next[24:9]  = offs_reg[idx];
                od_next[28:25] = SIG_WEIGHT[idx];
            end
            else
            begin
                os_next        = 1'b1;
                ol_next        = 1'b1;
                od_next[33:29] = cnt_reg;
                od_next[41:34] = tot_reg;
                od_next[45:42] = filter.enable ? filter.category : prim_reg;
                od_next[46]    = jovf_reg;
                job_valid_next = 1'b0;
                cnt_next       = '0;
                tot_next       = '0;
                best_next      = '0;
                prim_next      = '0;
            end
        end
        if (push.valid)
        begin
            job_valid_next = 1'b1;
            mask_next      = push.mask;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_valid_reg <= 1'b0;
            mask_reg      <= '0;
            cnt_reg       <= '0;
            tot_reg       <= '0;
            best_reg      <= '0;
            prim_reg      <= '0;
            ov_reg        <= 1'b0;
        end
        else
        begin
            job_valid_reg <= job_valid_next;
            mask_reg      <= mask_next;
            cnt_reg       <= cnt_next;
            tot_reg       <= tot_next;
            best_reg      <= best_next;
            prim_reg      <= prim_next;
            ov_reg        <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        os_reg <= os_next;
        ol_reg <= ol_next;
        od_reg <= od_next;
        if (push.valid)
        begin
            offs_reg <= push.offsets;
            jovf_reg <= push.overflow;
        end
    end

endmodule
`default_nettype wire

### hw/rtl/masked_signature_stream_scanner.sv
// Top level of the signature scanner: config registers, scanner and reporter.
//
//  channel   direction  handshake               payload
//  s_axis    in         s_tvalid / s_tready     tdata: data_byte, file_addr; tlast: last_byte
//  m_axis    out        m_tvalid / m_tready     tdata: result fields; tuser: is_summary;
//                                               tlast: end_of_run
//  cfg       in         cfg_valid / cfg_ready   cfg_index, cfg_data
//
// One byte per cycle; all 27 compares run in parallel on the byte window.
// Each file is sent one item per cycle while m_tready is high: up to 16 matches plus summary.
// A closing byte stalls only while the previous file is still being reported.
// rst_n clears the window, hit flags, counters and filter registers.
`timescale 1ns / 1ps
`default_nettype none
module masked_signature_stream_scanner (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [mssc_pkg::IN_DATA_W-1:0]     s_tdata,  // data_byte, file_addr
    input  wire logic                               s_tlast,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // sig_index, category, first_ofs, score, hit_count, score_sum,
    // top_cat, length_overflow, zero pad
    output logic [mssc_pkg::OUT_DATA_W-1:0]         m_tdata,
    output logic                                    m_tuser,  // is_summary
    output logic                                    m_tlast,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [mssc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [mssc_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import mssc_pkg::*;

    filter_t  filter_reg;
    job_t     push;
    logic     job_full;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filter_reg <= '0;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == REG_FILTER_ENABLE)
            begin
                filter_reg.enable <= cfg_data[0];
            end
            else if (cfg_index == REG_FILTER_CATEGORY)
            begin
                filter_reg.category <= cfg_data;
            end
        end
    end

    mssc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .data_byte (s_tdata[7:0]),
        .last_byte (s_tlast),
        .file_addr (s_tdata[23:8]),
        .filter    (filter_reg),
        .job_full  (job_full),
        .push      (push)
    );

    mssc_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .filter      (filter_reg),
        .job_full    (job_full),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_summary (m_tuser),
        .out_last    (m_tlast),
        .out_data    (m_tdata)
    );

endmodule
`default_nettype wire
